@@ sv/pnfs_pkg.sv @@
// ----------------------------------------------------------------------------
// pnfs_pkg: shared types and constants for the nozzle fire sequencer
// Holds the sequencer phase encoding, register indexes and fixed field widths.
// ----------------------------------------------------------------------------
package pnfs_pkg;

  localparam int MASK_W  = 12;
  localparam int ADDR_W  = 4;
  localparam int PULSE_W = 8;
  localparam int TICK_W  = 16;

  localparam logic [TICK_W-1:0] TICK_SAT = '1;

  // Sequencer phases, one-hot.
  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_WAIT = 4'b0010,
    PH_ON   = 4'b0100,
    PH_OFF  = 4'b1000
  } phase_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_PULSE_ON  = 2'd0,
    REG_PULSE_OFF = 2'd1,
    REG_ROW_PER   = 2'd2,
    REG_UNUSED    = 2'd3
  } reg_idx_t;

  localparam logic KIND_TICK    = 1'b0;
  localparam logic KIND_REQUEST = 1'b1;

endpackage

@@ sv/printhead_nozzle_fire_sequencer_top.sv @@
// ----------------------------------------------------------------------------
// printhead_nozzle_fire_sequencer_top: row-based nozzle fire sequencer
// Latches a nozzle mask per row, paces rows by a period counter and walks
// the set mask bits, driving each nozzle address for the on time.
// ----------------------------------------------------------------------------
// Each accepted word has its result word registered in the output register.
// Throughput: one word per cycle while no result word is stalled. The state
// update and the lowest-set-bit search sit between the state registers and
// the output register.
// Reset (rst_n low, synchronous): sequencer idle, row counter saturated so
// the first row starts at once, registers at 6 / 5 / 800, output empty.
module printhead_nozzle_fire_sequencer_top
  import pnfs_pkg::*;
#(
  parameter int NOZZLE_COUNT = 12
) (
  input  logic               clk,
  input  logic               rst_n,

  // Input word channel.
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_kind,
  input  logic [MASK_W-1:0]  in_row_mask,

  // Result word channel.
  output logic               out_valid,
  input  logic               out_stall,
  output logic [ADDR_W-1:0]  out_mux_address,
  output logic               out_fire_active,
  output logic               out_busy_res,
  output logic               out_request_dropped,

  // Configuration write channel.
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [TICK_W-1:0]  cfg_data
);

  // Only mask bits below both the nozzle count and the mask width are fired.
  localparam int FIRE_BITS = (NOZZLE_COUNT < MASK_W) ? NOZZLE_COUNT : MASK_W;

  // Configuration registers.
  logic [PULSE_W-1:0] pulse_on_r;
  logic [PULSE_W-1:0] pulse_off_r;
  logic [TICK_W-1:0]  row_period_r;

  // Sequencer state.
  logic [MASK_W-1:0]  pending_mask_r, pending_mask_nxt;
  logic [ADDR_W-1:0]  nozzle_idx_r, nozzle_idx_nxt;
  phase_t             phase_r, phase_nxt;
  logic [PULSE_W-1:0] phase_cnt_r, phase_cnt_nxt;
  logic [TICK_W-1:0]  since_start_r, since_start_nxt;

  // Output register.
  logic               out_valid_r;
  logic [ADDR_W-1:0]  out_addr_r, out_addr_nxt;
  logic               out_fire_r, out_fire_nxt;
  logic               out_busy_r, out_busy_nxt;
  logic               out_drop_r, out_drop_nxt;

  logic               in_accept;
  logic               do_enter;
  logic [ADDR_W-1:0]  enter_from;
  logic               bit_found;
  logic [ADDR_W-1:0]  bit_pos;
  logic [TICK_W-1:0]  since_inc;

  // The output register frees up when its word is taken, so a new input word
  // can enter in the same cycle that the previous result leaves.
  assign in_stall  = out_valid_r & out_stall;
  assign in_accept = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;

  // Configuration writes. Writes to REG_UNUSED are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_on_r   <= PULSE_W'(6);
      pulse_off_r  <= PULSE_W'(5);
      row_period_r <= TICK_W'(800);
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_PULSE_ON:  pulse_on_r   <= cfg_data[PULSE_W-1:0];
        REG_PULSE_OFF: pulse_off_r  <= cfg_data[PULSE_W-1:0];
        REG_ROW_PER:   row_period_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // The tick counter saturates instead of wrapping, so a long idle stretch
  // always looks like the row period has passed.
  assign since_inc = (since_start_r == TICK_SAT) ? since_start_r
                                                 : since_start_r + TICK_W'(1);

  // Next-state logic for one accepted word.
  always_comb begin
    pending_mask_nxt = pending_mask_r;
    nozzle_idx_nxt   = nozzle_idx_r;
    phase_nxt        = phase_r;
    phase_cnt_nxt    = phase_cnt_r;
    since_start_nxt  = since_start_r;
    do_enter         = 1'b0;
    enter_from       = '0;
    out_drop_nxt     = 1'b0;
    bit_found        = 1'b0;
    bit_pos          = '0;

    if (in_kind == KIND_REQUEST) begin
      // A request is not a tick; while busy it is dropped and nothing moves.
      if (phase_r != PH_IDLE) begin
        out_drop_nxt = 1'b1;
      end else begin
        pending_mask_nxt = in_row_mask;
        if (since_start_r >= row_period_r) begin
          since_start_nxt = '0;
          do_enter        = 1'b1;
        end else begin
          phase_nxt = PH_WAIT;
        end
      end
    end else begin
      since_start_nxt = since_inc;
      unique case (phase_r)
        PH_WAIT: begin
          // The wait always compares against the current period register.
          if (since_inc >= row_period_r) begin
            since_start_nxt = '0;
            do_enter        = 1'b1;
          end
        end
        PH_ON: begin
          // An on time of zero behaves as one tick.
          if (phase_cnt_r <= PULSE_W'(1)) begin
            if (pulse_off_r == '0) begin
              do_enter   = 1'b1;
              enter_from = nozzle_idx_r + ADDR_W'(1);
            end else begin
              phase_nxt     = PH_OFF;
              phase_cnt_nxt = pulse_off_r;
            end
          end else begin
            phase_cnt_nxt = phase_cnt_r - PULSE_W'(1);
          end
        end
        PH_OFF: begin
          if (phase_cnt_r <= PULSE_W'(1)) begin
            do_enter   = 1'b1;
            enter_from = nozzle_idx_r + ADDR_W'(1);
          end else begin
            phase_cnt_nxt = phase_cnt_r - PULSE_W'(1);
          end
        end
        default: ;
      endcase
    end

    // Lowest set mask bit at or above enter_from. The search runs on the next
    // mask value so that a request that starts its row at once sees its own mask.
    for (int b = FIRE_BITS - 1; b >= 0; b--) begin
      if (pending_mask_nxt[b] && (ADDR_W'(b) >= enter_from)) begin
        bit_found = 1'b1;
        bit_pos   = ADDR_W'(b);
      end
    end

    // Move to the next nozzle to fire, or back to idle when the row is done.
    // An empty mask still counts as a started row.
    if (do_enter) begin
      if (bit_found) begin
        nozzle_idx_nxt = bit_pos;
        phase_nxt      = PH_ON;
        phase_cnt_nxt  = pulse_on_r;
      end else begin
        phase_nxt     = PH_IDLE;
        phase_cnt_nxt = '0;
      end
    end

    // The result word shows the state after this word.
    out_fire_nxt = (phase_nxt == PH_ON);
    out_addr_nxt = out_fire_nxt ? nozzle_idx_nxt + ADDR_W'(1) : '0;
    out_busy_nxt = (phase_nxt != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_mask_r <= '0;
      nozzle_idx_r   <= '0;
      phase_r        <= PH_IDLE;
      phase_cnt_r    <= '0;
      since_start_r  <= TICK_SAT;
      out_valid_r    <= 1'b0;
    end else begin
      if (in_accept) begin
        pending_mask_r <= pending_mask_nxt;
        nozzle_idx_r   <= nozzle_idx_nxt;
        phase_r        <= phase_nxt;
        phase_cnt_r    <= phase_cnt_nxt;
        since_start_r  <= since_start_nxt;
        out_valid_r    <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r    <= 1'b0;
      end
    end
  end

  // Result payload; held while the word waits to be taken.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_addr_r <= out_addr_nxt;
      out_fire_r <= out_fire_nxt;
      out_busy_r <= out_busy_nxt;
      out_drop_r <= out_drop_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_mux_address     = out_addr_r;
  assign out_fire_active     = out_fire_r;
  assign out_busy_res        = out_busy_r;
  assign out_request_dropped = out_drop_r;

endmodule
